// ===== hw/rtl/vrdd_pkg.sv =====
`default_nettype none

package vrdd_pkg;

  localparam int VEL_W   = 16;
  localparam int STEP_W  = 15;
  localparam int GAIN_W  = 24;
  localparam int WHEEL_W = 24;
  localparam int PROD_W  = VEL_W + GAIN_W + 1;
  localparam int FRAC_W  = 16;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 24;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 80;

  localparam logic [CFG_ADDR_W-1:0] CFG_ACCEL_STEP      = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_DECEL_STEP      = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_ROT_ACCEL_STEP  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_ROT_DECEL_STEP  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_ROT_RAMP_ENABLE = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_LINEAR_GAIN     = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] CFG_ROTATION_GAIN   = 3'd6;

  localparam logic [STEP_W-1:0] ACCEL_STEP_RST = 15'd50;
  localparam logic [STEP_W-1:0] DECEL_STEP_RST = 15'd100;
  localparam logic [GAIN_W-1:0] GAIN_RST       = 24'd65536;

  typedef logic signed [VEL_W-1:0]   vel_t;
  typedef logic [STEP_W-1:0]         step_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [WHEEL_W-1:0] wheel_t;

endpackage

`default_nettype wire

// ===== hw/rtl/vrdd_ramp.sv =====
`default_nettype none

module vrdd_ramp (
  input  var vrdd_pkg::vel_t  cur,
  input  var vrdd_pkg::vel_t  tgt,
  input  var vrdd_pkg::step_t acc_step,
  input  var vrdd_pkg::step_t dec_step,
  output vrdd_pkg::vel_t      res
);

  logic signed [17:0] c_e;
  logic signed [17:0] t_e;
  logic signed [17:0] a_e;
  logic signed [17:0] d_e;
  logic signed [17:0] c_up_a;
  logic signed [17:0] c_dn_d;
  logic signed [17:0] c_dn_a;
  logic signed [17:0] c_up_d;
  logic signed [17:0] raw;

  always_comb begin
    c_e    = {{2{cur[15]}}, cur};
    t_e    = {{2{tgt[15]}}, tgt};
    a_e    = {3'b000, acc_step};
    d_e    = {3'b000, dec_step};
    c_up_a = c_e + a_e;
    c_dn_d = c_e - d_e;
    c_dn_a = c_e - a_e;
    c_up_d = c_e + d_e;
    if (!cur[15]) begin
      if (t_e > c_up_a) begin
        raw = c_up_a;
      end else if (t_e < c_dn_d) begin
        raw = c_dn_d;
      end else begin
        raw = t_e;
      end
    end else begin
      if (t_e < c_dn_a) begin
        raw = c_dn_a;
      end else if (t_e > c_up_d) begin
        raw = c_up_d;
      end else begin
        raw = t_e;
      end
    end
    if (raw > 18'sd32767) begin
      res = 16'sh7fff;
    end else if (raw < -18'sd32768) begin
      res = 16'sh8000;
    end else begin
      res = raw[15:0];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/vrdd_wheel.sv =====
`default_nettype none

module vrdd_wheel (
  input  var vrdd_pkg::prod_t lin_prod,
  input  var vrdd_pkg::prod_t rot_prod,
  output vrdd_pkg::wheel_t    left_speed,
  output vrdd_pkg::wheel_t    right_speed
);

  localparam int SUM_W = vrdd_pkg::PROD_W + 1;
  localparam int Q_W   = SUM_W - vrdd_pkg::FRAC_W;

  logic signed [SUM_W-1:0] lin_e;
  logic signed [SUM_W-1:0] rot_e;
  logic signed [SUM_W-1:0] half;
  logic signed [SUM_W-1:0] left_sum;
  logic signed [SUM_W-1:0] right_sum;
  logic signed [Q_W-1:0]   left_q;
  logic signed [Q_W-1:0]   right_q;
  logic signed [Q_W-1:0]   q_max;
  logic signed [Q_W-1:0]   q_min;

  always_comb begin
    lin_e     = {lin_prod[vrdd_pkg::PROD_W-1], lin_prod};
    rot_e     = {rot_prod[vrdd_pkg::PROD_W-1], rot_prod};
    half      = SUM_W'(1) <<< (vrdd_pkg::FRAC_W - 1);
    left_sum  = lin_e - rot_e + half;
    right_sum = lin_e + rot_e + half;
    left_q    = left_sum[SUM_W-1:vrdd_pkg::FRAC_W];
    right_q   = right_sum[SUM_W-1:vrdd_pkg::FRAC_W];
    q_max     = {{(Q_W-vrdd_pkg::WHEEL_W+1){1'b0}}, {(vrdd_pkg::WHEEL_W-1){1'b1}}};
    q_min     = ~q_max;

    if (left_q > q_max) begin
      left_speed = {1'b0, {(vrdd_pkg::WHEEL_W-1){1'b1}}};
    end else if (left_q < q_min) begin
      left_speed = {1'b1, {(vrdd_pkg::WHEEL_W-1){1'b0}}};
    end else begin
      left_speed = left_q[vrdd_pkg::WHEEL_W-1:0];
    end

    if (right_q > q_max) begin
      right_speed = {1'b0, {(vrdd_pkg::WHEEL_W-1){1'b1}}};
    end else if (right_q < q_min) begin
      right_speed = {1'b1, {(vrdd_pkg::WHEEL_W-1){1'b0}}};
    end else begin
      right_speed = right_q[vrdd_pkg::WHEEL_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/velocity_ramp_diff_drive_top.sv =====
// An accepted item is registered in s1, then s2 (gain products), then out_tdata.
// Throughput: one item per cycle unless out_tready stalls; the ramp state update is
// the only loop, the two gain multiplies and the round/saturate stage are pipelined.
// Reset: synchronous, active low on rst_n; it empties the pipeline, clears the
// ramp state to zero and restores every configuration register to its default.
`default_nettype none

module velocity_ramp_diff_drive_top (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_tvalid,
  output logic                               in_tready,
  // target_forward [15:0], target_rotation [31:16]
  input  wire  [vrdd_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                               out_tvalid,
  input  wire                                out_tready,
  // ramped_forward [15:0], ramped_rotation [31:16],
  // left_wheel_speed [55:32], right_wheel_speed [79:56]
  output logic [vrdd_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  wire                                cfg_we,
  input  wire  [vrdd_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  wire  [vrdd_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  vrdd_pkg::step_t                    accel_r;
  vrdd_pkg::step_t                    decel_r;
  vrdd_pkg::step_t                    rot_accel_r;
  vrdd_pkg::step_t                    rot_decel_r;
  logic                               rot_en_r;
  logic [vrdd_pkg::GAIN_W-1:0]        lin_gain_r;
  logic [vrdd_pkg::GAIN_W-1:0]        rot_gain_r;

  vrdd_pkg::vel_t  cur_fwd_r;
  vrdd_pkg::vel_t  cur_rot_r;
  vrdd_pkg::vel_t  fwd_nxt;
  vrdd_pkg::vel_t  rot_ramped;
  vrdd_pkg::vel_t  rot_nxt;
  vrdd_pkg::vel_t  tgt_fwd;
  vrdd_pkg::vel_t  tgt_rot;

  logic            s1_valid_r;
  vrdd_pkg::vel_t  s1_fwd_r;
  vrdd_pkg::vel_t  s1_rot_r;
  logic            s2_valid_r;
  vrdd_pkg::vel_t  s2_fwd_r;
  vrdd_pkg::vel_t  s2_rot_r;
  vrdd_pkg::prod_t lin_prod_r;
  vrdd_pkg::prod_t rot_prod_r;
  logic            out_valid_r;
  logic [vrdd_pkg::OUT_DATA_W-1:0] out_data_r;

  vrdd_pkg::wheel_t left_speed;
  vrdd_pkg::wheel_t right_speed;

  logic in_accept;
  logic out_rdy;
  logic s2_rdy;
  logic s1_rdy;

  logic signed [16:0] fwd_delta;
  logic        [16:0] fwd_mag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_r     <= vrdd_pkg::ACCEL_STEP_RST;
      decel_r     <= vrdd_pkg::DECEL_STEP_RST;
      rot_accel_r <= vrdd_pkg::ACCEL_STEP_RST;
      rot_decel_r <= vrdd_pkg::DECEL_STEP_RST;
      rot_en_r    <= 1'b0;
      lin_gain_r  <= vrdd_pkg::GAIN_RST;
      rot_gain_r  <= vrdd_pkg::GAIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        vrdd_pkg::CFG_ACCEL_STEP:      accel_r     <= cfg_wdata[vrdd_pkg::STEP_W-1:0];
        vrdd_pkg::CFG_DECEL_STEP:      decel_r     <= cfg_wdata[vrdd_pkg::STEP_W-1:0];
        vrdd_pkg::CFG_ROT_ACCEL_STEP:  rot_accel_r <= cfg_wdata[vrdd_pkg::STEP_W-1:0];
        vrdd_pkg::CFG_ROT_DECEL_STEP:  rot_decel_r <= cfg_wdata[vrdd_pkg::STEP_W-1:0];
        vrdd_pkg::CFG_ROT_RAMP_ENABLE: rot_en_r    <= cfg_wdata[0];
        vrdd_pkg::CFG_LINEAR_GAIN:     lin_gain_r  <= cfg_wdata[vrdd_pkg::GAIN_W-1:0];
        vrdd_pkg::CFG_ROTATION_GAIN:   rot_gain_r  <= cfg_wdata[vrdd_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign tgt_fwd = in_tdata[15:0];
  assign tgt_rot = in_tdata[31:16];

  vrdd_ramp u_ramp_fwd (
    .cur      (cur_fwd_r),
    .tgt      (tgt_fwd),
    .acc_step (accel_r),
    .dec_step (decel_r),
    .res      (fwd_nxt)
  );

  vrdd_ramp u_ramp_rot (
    .cur      (cur_rot_r),
    .tgt      (tgt_rot),
    .acc_step (rot_accel_r),
    .dec_step (rot_decel_r),
    .res      (rot_ramped)
  );

  assign rot_nxt = rot_en_r ? rot_ramped : tgt_rot;

  assign out_rdy   = !out_valid_r || out_tready;
  assign s2_rdy    = !s2_valid_r || out_rdy;
  assign s1_rdy    = !s1_valid_r || s2_rdy;
  assign in_tready = s1_rdy;
  assign in_accept = in_tvalid && s1_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_fwd_r   <= '0;
      cur_rot_r   <= '0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        cur_fwd_r <= fwd_nxt;
        cur_rot_r <= rot_nxt;
      end
      if (s1_rdy) begin
        s1_valid_r <= in_tvalid;
      end
      if (s2_rdy) begin
        s2_valid_r <= s1_valid_r;
      end
      if (out_rdy) begin
        out_valid_r <= s2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_fwd_r <= fwd_nxt;
      s1_rot_r <= rot_nxt;
    end
    if (s2_rdy && s1_valid_r) begin
      s2_fwd_r   <= s1_fwd_r;
      s2_rot_r   <= s1_rot_r;
      lin_prod_r <= vrdd_pkg::prod_t'(s1_fwd_r) *
                    vrdd_pkg::prod_t'($signed({1'b0, lin_gain_r}));
      rot_prod_r <= vrdd_pkg::prod_t'(s1_rot_r) *
                    vrdd_pkg::prod_t'($signed({1'b0, rot_gain_r}));
    end
    if (out_rdy && s2_valid_r) begin
      out_data_r <= {right_speed, left_speed, s2_rot_r, s2_fwd_r};
    end
  end

  vrdd_wheel u_wheel (
    .lin_prod    (lin_prod_r),
    .rot_prod    (rot_prod_r),
    .left_speed  (left_speed),
    .right_speed (right_speed)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    fwd_delta = {fwd_nxt[15], fwd_nxt} - {cur_fwd_r[15], cur_fwd_r};
    fwd_mag   = fwd_delta[16] ? 17'(-fwd_delta) : 17'(fwd_delta);
  end

  a_fwd_step_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |-> (fwd_mag <= {2'b00, accel_r}) || (fwd_mag <= {2'b00, decel_r}))
    else $error("forward ramp step exceeds both limits");

  a_rot_passthrough: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && !rot_en_r |=> cur_rot_r == $past(tgt_rot))
    else $error("rotation target not passed through with ramp disabled");

  a_stage1_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> s1_valid_r && s1_fwd_r == cur_fwd_r && s1_rot_r == cur_rot_r)
    else $error("first stage lost track of ramp state");

  a_no_accept_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s2_valid_r && out_valid_r && !out_tready |-> !in_tready)
    else $error("item accepted while pipeline is full and stalled");

endmodule

`default_nettype wire
